// ===== sv/sky_face_projected_bounds_defines.svh =====
// Assertion macros shared by the sky face bounds RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SKY_FACE_PROJECTED_BOUNDS_DEFINES_SVH
`define SKY_FACE_PROJECTED_BOUNDS_DEFINES_SVH

// same-cycle implication
`define SFPB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfpb assertion failed");

// next-cycle implication
`define SFPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfpb assertion failed");

`endif

// ===== sv/sfpb_pkg.sv =====
// Types, sizes and face selection helpers for the sky face bounds block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfpb_pkg;
  localparam int MAX_VERTS  = 64;
  localparam int COORD_BITS = 24;
  localparam int ADDR_W     = $clog2(MAX_VERTS);
  localparam int CNT_W      = $clog2(MAX_VERTS + 1);
  localparam int CW         = COORD_BITS + 1;
  localparam int SUM_W      = COORD_BITS + CNT_W;
  localparam int NFACES     = 6;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_VERTEX = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q_MIN = 16'sh8000;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         last_vertex;
    logic [2:0]                   read_face;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         face;
    logic signed [15:0] s_min;
    logic signed [15:0] t_min;
    logic signed [15:0] s_max;
    logic signed [15:0] t_max;
    logic               visible;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] num;
    logic [COORD_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic signed [15:0] s_min;
    logic signed [15:0] t_min;
    logic signed [15:0] s_max;
    logic signed [15:0] t_max;
  } bounds_t;

  // which: 0 s, 1 t, 2 depth
  function automatic logic signed [CW-1:0] pick_comp(input logic [2:0] f,
      input logic [1:0] which, input logic signed [CW-1:0] x,
      input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
    logic signed [CW-1:0] r;
    r = z;
    unique case (f)
      FACE_PX: r = (which == 2'd0) ? -y : (which == 2'd1) ? z : x;
      FACE_NX: r = (which == 2'd0) ? y : (which == 2'd1) ? z : -x;
      FACE_PY: r = (which == 2'd0) ? x : (which == 2'd1) ? z : y;
      FACE_NY: r = (which == 2'd0) ? -x : (which == 2'd1) ? z : -y;
      FACE_PZ: r = (which == 2'd0) ? -y : (which == 2'd1) ? -x : z;
      FACE_NZ: r = (which == 2'd0) ? -y : (which == 2'd1) ? x : -z;
      default: r = z;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/sfpb_div.sv =====
// Sequential restoring divider: coordinate times 2^14 over depth, Q2.14 saturated.
// Depends on sfpb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfpb_div import sfpb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire div_req_t           req,
  output logic                    done,
  output logic signed [15:0]      res
);
  logic [COORD_BITS-1:0] r_r, den_r, mag;
  logic [15:0]           q_r;
  logic [3:0]            cnt_r;
  logic [1:0]            lb_r;
  logic                  busy_r, done_r, neg_r, ov_r;
  logic                  nb, ge;
  logic [COORD_BITS:0]   r2, diff;
  logic signed [CW-1:0]  neg_num;

  always_comb begin
    neg_num = -req.num;
    mag  = req.num[CW-1] ? neg_num[COORD_BITS-1:0] : req.num[COORD_BITS-1:0];
    nb   = (cnt_r == 4'd15) ? lb_r[1] : (cnt_r == 4'd14) ? lb_r[0] : 1'b0;
    r2   = {r_r, nb};
    ge   = r2 >= {1'b0, den_r};
    diff = r2 - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd15;
        r_r    <= mag >> 2;
        lb_r   <= mag[1:0];
        q_r    <= '0;
        neg_r  <= req.num[CW-1];
        ov_r   <= {2'b00, mag} >= {req.den, 2'b00};
        den_r  <= req.den;
      end else if (busy_r) begin
        r_r   <= ge ? diff[COORD_BITS-1:0] : r2[COORD_BITS-1:0];
        q_r   <= {q_r[14:0], ge};
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;

  always_comb begin
    if (neg_r) begin
      res = (ov_r || q_r > 16'd32768) ? Q_MIN : $signed(~q_r + 16'd1);
    end else begin
      res = (ov_r || q_r[15]) ? Q_MAX : $signed(q_r);
    end
  end
endmodule
`default_nettype wire

// ===== sv/sky_face_projected_bounds.sv =====
// Sky face projected bounds: vertex store, face choice, projection and face bounds.
// Depends on sfpb_pkg, sfpb_div and sky_face_projected_bounds_defines.svh.
//
// Use: in_valid/in_ready carry one request: clear all faces, one polygon vertex
// or a read of one face. A vertex is written to the vertex memory; clear gives
// no result. The vertex marked last starts the projection pass: a face-choice
// step, then for each stored vertex a memory read and a check, and for a vertex
// deep enough a divide by the pair of serial dividers and an update; no new
// request is taken until the pass ends. The result is then registered in the
// output register. A read passes through the read state before its result is
// registered in the output register in the same way.
// out_valid/out_ready carry results; a held result does not block a new request
// that gives no result, but a read or last vertex waits for the register.
// cfg_valid/cfg_ready write min_depth, always ready.
// After reset (rst_n low, synchronous) all faces are empty, min_depth is 1 and
// no polygon is open; the vertex memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sky_face_projected_bounds_defines.svh"
module sky_face_projected_bounds import sfpb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [7:0] cfg_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_FACE, S_RD, S_CHK, S_DIV, S_UPD, S_EMIT, S_READ
  } state_t;

  state_t state_r;
  logic [7:0] min_depth_r;
  logic [3*COORD_BITS-1:0] vmem [MAX_VERTS];
  logic [3*COORD_BITS-1:0] rd_q;
  logic signed [SUM_W-1:0] sx_r, sy_r, sz_r;
  logic [CNT_W-1:0] cnt_r, idx_r;
  logic ovf_r;
  logic [2:0] face_r;
  bounds_t bnd_r [NFACES];
  logic out_valid_r;
  out_item_t out_data_r;

  logic in_acc, out_free, emit_go;
  logic signed [CW-1:0] cx, cy, cz, dv, sn, tn;
  logic skip, last_idx;
  logic [SUM_W-1:0] ax, ay, az;
  logic [2:0] face_nxt;
  div_req_t sreq, treq;
  logic s_done, t_done;
  logic signed [15:0] s_res, t_res;
  bounds_t eb;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign emit_go   = ((state_r == S_EMIT) || (state_r == S_READ)) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cx = CW'($signed(rd_q[3*COORD_BITS-1:2*COORD_BITS]));
    cy = CW'($signed(rd_q[2*COORD_BITS-1:COORD_BITS]));
    cz = CW'($signed(rd_q[COORD_BITS-1:0]));
    dv = pick_comp(face_r, 2'd2, cx, cy, cz);
    sn = pick_comp(face_r, 2'd0, cx, cy, cz);
    tn = pick_comp(face_r, 2'd1, cx, cy, cz);
    skip = (dv <= 0) || (dv < $signed({{(CW-8){1'b0}}, min_depth_r}));
    last_idx = (idx_r + CNT_W'(1)) >= cnt_r;
    sreq.start = (state_r == S_CHK) && !skip;
    sreq.num   = sn;
    sreq.den   = dv[COORD_BITS-1:0];
    treq.start = sreq.start;
    treq.num   = tn;
    treq.den   = dv[COORD_BITS-1:0];
    ax = sx_r[SUM_W-1] ? SUM_W'(-sx_r) : SUM_W'(sx_r);
    ay = sy_r[SUM_W-1] ? SUM_W'(-sy_r) : SUM_W'(sy_r);
    az = sz_r[SUM_W-1] ? SUM_W'(-sz_r) : SUM_W'(sz_r);
    priority if (ax > ay && ax > az) begin
      face_nxt = sx_r[SUM_W-1] ? FACE_NX : FACE_PX;
    end else if (ay > az && ay > ax) begin
      face_nxt = sy_r[SUM_W-1] ? FACE_NY : FACE_PY;
    end else begin
      face_nxt = sz_r[SUM_W-1] ? FACE_NZ : FACE_PZ;
    end
    eb = bnd_r[face_r];
  end

  sfpb_div u_div_s (.clk(clk), .rst_n(rst_n), .req(sreq), .done(s_done), .res(s_res));
  sfpb_div u_div_t (.clk(clk), .rst_n(rst_n), .req(treq), .done(t_done), .res(t_res));

  // vertex memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && in_data.cmd == CMD_VERTEX && cnt_r < CNT_W'(MAX_VERTS)) begin
      vmem[cnt_r[ADDR_W-1:0]] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
    end
    if (state_r == S_RD) begin
      rd_q <= vmem[idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_depth_r <= 8'd1;
      sx_r        <= '0;
      sy_r        <= '0;
      sz_r        <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      face_r      <= FACE_PZ;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NFACES; i++) begin
        bnd_r[i] <= '{Q_MAX, Q_MAX, Q_MIN, Q_MIN};
      end
    end else begin
      if (cfg_valid) begin
        min_depth_r <= cfg_data;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_data.cmd)
              CMD_CLEAR: begin
                for (int i = 0; i < NFACES; i++) begin
                  bnd_r[i] <= '{Q_MAX, Q_MAX, Q_MIN, Q_MIN};
                end
              end
              CMD_VERTEX: begin
                if (cnt_r < CNT_W'(MAX_VERTS)) begin
                  sx_r  <= sx_r + SUM_W'(in_data.pos_x);
                  sy_r  <= sy_r + SUM_W'(in_data.pos_y);
                  sz_r  <= sz_r + SUM_W'(in_data.pos_z);
                  cnt_r <= cnt_r + CNT_W'(1);
                end else begin
                  ovf_r <= 1'b1;
                end
                if (in_data.last_vertex) begin
                  state_r <= S_FACE;
                end
              end
              CMD_READ: begin
                face_r  <= (in_data.read_face > FACE_NZ) ? FACE_NZ : in_data.read_face;
                state_r <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_FACE: begin
          face_r  <= face_nxt;
          idx_r   <= '0;
          state_r <= (cnt_r == '0) ? S_EMIT : S_RD;
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (!skip) begin
            state_r <= S_DIV;
          end else begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= last_idx ? S_EMIT : S_RD;
          end
        end
        S_DIV: begin
          if (s_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (s_res < eb.s_min) bnd_r[face_r].s_min <= s_res;
          if (t_res < eb.t_min) bnd_r[face_r].t_min <= t_res;
          if (s_res > eb.s_max) bnd_r[face_r].s_max <= s_res;
          if (t_res > eb.t_max) bnd_r[face_r].t_max <= t_res;
          idx_r   <= idx_r + CNT_W'(1);
          state_r <= last_idx ? S_EMIT : S_RD;
        end
        S_EMIT, S_READ: begin
          if (out_free) begin
            out_data_r.face    <= face_r;
            out_data_r.s_min   <= eb.s_min;
            out_data_r.t_min   <= eb.t_min;
            out_data_r.s_max   <= eb.s_max;
            out_data_r.t_max   <= eb.t_max;
            out_data_r.visible <= (eb.s_min < eb.s_max) && (eb.t_min < eb.t_max);
            out_data_r.status  <= (state_r == S_EMIT) ? ovf_r : 1'b0;
            if (state_r == S_EMIT) begin
              sx_r  <= '0;
              sy_r  <= '0;
              sz_r  <= '0;
              cnt_r <= '0;
              ovf_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SFPB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_VERTS))
  `SFPB_ASSERT_NOW(a_div_pair, s_done, t_done)
  `SFPB_ASSERT_NOW(a_face_range, out_valid_r, out_data_r.face <= FACE_NZ)
  `SFPB_ASSERT_NEXT(a_cnt_step,
    in_acc && in_data.cmd == CMD_VERTEX && cnt_r < CNT_W'(MAX_VERTS),
    cnt_r == $past(cnt_r) + CNT_W'(1))
endmodule
`default_nettype wire
